// ----- rtl/uqp_pkg.sv -----
// Package for the URL query stream parser: phase codes, target codes,
// character constants, state and result structs, and byte helper functions.
// No dependencies.
package uqp_pkg;

  // Parse phase, one-hot
  typedef enum logic [4:0] {
    PH_URL        = 5'b00001,
    PH_URL_DONE   = 5'b00010,
    PH_PARAM_DONE = 5'b00100,
    PH_NAME       = 5'b01000,
    PH_VALUE      = 5'b10000
  } phase_t;

  // Phase codes as reported on the result
  localparam logic [2:0] CODE_URL        = 3'd0;
  localparam logic [2:0] CODE_URL_DONE   = 3'd1;
  localparam logic [2:0] CODE_PARAM_DONE = 3'd2;
  localparam logic [2:0] CODE_NAME       = 3'd3;
  localparam logic [2:0] CODE_VALUE      = 3'd4;

  // Emit targets
  typedef logic [1:0] target_t;
  localparam target_t TGT_URL   = 2'd0;
  localparam target_t TGT_NAME  = 2'd1;
  localparam target_t TGT_VALUE = 2'd2;

  // Input op codes
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_END  = 1'b1;

  // Characters
  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [7:0] CH_AMP      = 8'h26;
  localparam logic [7:0] CH_EQUALS   = 8'h3D;
  localparam logic [7:0] CH_PERCENT  = 8'h25;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_SPACE    = 8'h20;

  // Decode digit counter: 0 idle, 1 after '%', 2 after first digit
  localparam logic [1:0] DEC_IDLE  = 2'd0;
  localparam logic [1:0] DEC_START = 2'd1;
  localparam logic [1:0] DEC_LAST  = 2'd2;
  localparam logic [1:0] DEC_WRAP  = 2'd3;

  typedef struct packed {
    phase_t     phase;
    logic [1:0] dec_count;
    logic [7:0] dec_value;
  } parse_state_t;

  typedef struct packed {
    logic       emit_valid;
    logic [7:0] emit_byte;
    target_t    emit_target;
    logic [2:0] parse_phase;
  } parse_result_t;

  // Lower-case 'A'..'Z' only
  function automatic logic [7:0] lower_byte(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) r = c + 8'd32;
    return r;
  endfunction

  // Hex digit value; anything else reads as zero
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] r;
    r = 8'd0;
    if (c >= 8'h30 && c <= 8'h39)      r = c - 8'h30;
    else if (c >= 8'h61 && c <= 8'h66) r = c - 8'h61 + 8'd10;
    else if (c >= 8'h41 && c <= 8'h46) r = c - 8'h41 + 8'd10;
    return r[3:0];
  endfunction

  function automatic logic [2:0] phase_code(input phase_t p);
    logic [2:0] r;
    unique case (p)
      PH_URL:        r = CODE_URL;
      PH_URL_DONE:   r = CODE_URL_DONE;
      PH_PARAM_DONE: r = CODE_PARAM_DONE;
      PH_NAME:       r = CODE_NAME;
      PH_VALUE:      r = CODE_VALUE;
      default:       r = CODE_URL;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/uqp_in_if.sv -----
// Input channel interface: one URL byte or end marker per transaction.
// Depends on nothing.
interface uqp_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] char_in;
  logic       param_present;

  modport source (output valid, op, char_in, param_present, input ready);
  modport sink   (input valid, op, char_in, param_present, output ready);
endinterface

// ----- rtl/uqp_out_if.sv -----
// Output channel interface: one parse result per transaction.
// Depends on nothing.
interface uqp_out_if;
  logic       valid;
  logic       ready;
  logic       emit_valid;
  logic [7:0] emit_byte;
  logic [1:0] emit_target;
  logic [2:0] parse_phase;

  modport source (output valid, emit_valid, emit_byte, emit_target, parse_phase, input ready);
  modport sink   (input valid, emit_valid, emit_byte, emit_target, parse_phase, output ready);
endinterface

// ----- rtl/uqp_step.sv -----
// Per-byte next-state and result logic of the URL query parser.
// Depends on uqp_pkg.
module uqp_step (
  input  uqp_pkg::parse_state_t  cur,
  input  logic                   op,
  input  logic [7:0]             char_in,
  input  logic                   param_present,
  output uqp_pkg::parse_state_t  nxt,
  output uqp_pkg::parse_result_t res
);
  import uqp_pkg::*;

  logic       dec_done;
  logic [1:0] dec_count_inc;
  logic [7:0] dec_value_shift;

  // Percent decode datapath: shift in one hex digit
  assign dec_value_shift = {cur.dec_value[3:0], hex_nibble(char_in)};
  assign dec_count_inc   = cur.dec_count + 2'd1;
  assign dec_done        = (cur.dec_count == DEC_LAST) || (cur.dec_count == DEC_WRAP);

  always_comb begin
    nxt             = cur;
    res.emit_valid  = 1'b0;
    res.emit_byte   = 8'd0;
    res.emit_target = TGT_URL;

    priority if (op == OP_END) begin
      // End marker closes the url or the open parameter
      priority if (cur.phase == PH_URL) nxt.phase = PH_URL_DONE;
      else if (cur.phase == PH_NAME || cur.phase == PH_VALUE) nxt.phase = PH_PARAM_DONE;
      else nxt.phase = cur.phase;
    end else if (char_in != 8'd0) begin
      unique case (cur.phase)
        PH_URL: begin
          if (char_in == CH_QUESTION) begin
            nxt.phase = PH_URL_DONE;
          end else begin
            res.emit_valid = 1'b1;
            res.emit_byte  = lower_byte(char_in);
          end
        end
        PH_URL_DONE, PH_PARAM_DONE, PH_NAME: begin
          priority if (char_in == CH_AMP) begin
            nxt.phase     = PH_PARAM_DONE;
            nxt.dec_count = DEC_IDLE;
          end else if (char_in == CH_EQUALS) begin
            nxt.phase     = PH_VALUE;
            nxt.dec_count = DEC_IDLE;
          end else if (char_in == CH_PERCENT) begin
            nxt.dec_count = DEC_START;
            nxt.dec_value = 8'd0;
          end else if (param_present) begin
            if (cur.dec_count != DEC_IDLE) begin
              nxt.dec_value  = dec_value_shift;
              nxt.dec_count  = dec_done ? DEC_IDLE : dec_count_inc;
              res.emit_valid = dec_done;
              res.emit_byte  = dec_done ? dec_value_shift : 8'd0;
            end else begin
              res.emit_valid = 1'b1;
              res.emit_byte  = (char_in == CH_PLUS) ? CH_SPACE : lower_byte(char_in);
            end
            res.emit_target = res.emit_valid ? TGT_NAME : TGT_URL;
            nxt.phase       = PH_NAME;
          end else begin
            nxt.phase = cur.phase;
          end
        end
        PH_VALUE: begin
          priority if (char_in == CH_AMP) begin
            nxt.phase     = PH_PARAM_DONE;
            nxt.dec_count = DEC_IDLE;
          end else if (char_in == CH_PERCENT) begin
            nxt.dec_count = DEC_START;
            nxt.dec_value = 8'd0;
          end else if (param_present) begin
            if (cur.dec_count != DEC_IDLE) begin
              nxt.dec_value  = dec_value_shift;
              nxt.dec_count  = dec_done ? DEC_IDLE : dec_count_inc;
              res.emit_valid = dec_done;
              res.emit_byte  = dec_done ? dec_value_shift : 8'd0;
            end else begin
              res.emit_valid = 1'b1;
              res.emit_byte  = (char_in == CH_PLUS) ? CH_SPACE : char_in;
            end
            res.emit_target = res.emit_valid ? TGT_VALUE : TGT_URL;
          end else begin
            nxt.phase = cur.phase;
          end
        end
        default: nxt = cur;
      endcase
    end else begin
      nxt = cur;
    end

    res.parse_phase = phase_code(nxt.phase);
  end

endmodule

// ----- rtl/url_query_stream_parser.sv -----
// URL query stream parser: each result is registered and valid in the cycle after
// its input transaction; throughput one per cycle while the sink takes results.
// The parse state and the result register update at the same edge; a held
// result still lets the next byte in once the sink takes it.
// Reset (rst, synchronous): phase back to url path, decode idle, output empty.
module url_query_stream_parser (
  input  logic clk,
  input  logic rst,
  uqp_in_if.sink    in_ch,
  uqp_out_if.source out_ch
);
  import uqp_pkg::*;

  parse_state_t  state;
  parse_state_t  state_next;
  parse_result_t step_res;
  parse_result_t out_res;
  logic          out_valid;
  logic          in_accept;

  // Accept whenever the result register is empty or draining this cycle
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign in_accept   = in_ch.valid && in_ch.ready;

  uqp_step u_step (
    .cur           (state),
    .op            (in_ch.op),
    .char_in       (in_ch.char_in),
    .param_present (in_ch.param_present),
    .nxt           (state_next),
    .res           (step_res)
  );

  // Parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase     <= PH_URL;
      state.dec_count <= DEC_IDLE;
      state.dec_value <= 8'd0;
    end else if (in_accept) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) out_res <= step_res;
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.emit_valid  = out_res.emit_valid;
  assign out_ch.emit_byte   = out_res.emit_byte;
  assign out_ch.emit_target = out_res.emit_target;
  assign out_ch.parse_phase = out_res.parse_phase;

  // Decode counter never rests at the wrap code
  a_dec_count_range: assert property (@(posedge clk) disable iff (rst)
    state.dec_count != DEC_WRAP)
    else $error("decode counter reached wrap code");

  // An end marker never leaves the parser in the url phase
  a_end_leaves_url: assert property (@(posedge clk) disable iff (rst)
    in_accept && in_ch.op == OP_END |=> out_ch.valid && out_ch.parse_phase != CODE_URL)
    else $error("end marker left parser in url phase");

  // A name byte is only reported with the name phase
  a_name_phase: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.emit_valid && out_ch.emit_target == TGT_NAME
      |-> out_ch.parse_phase == CODE_NAME)
    else $error("name byte emitted outside name phase");

endmodule
